FILE: rtl/tklr_pkg.sv
// Shared types and constants for the top-k lifetime retainer.
`timescale 1ns / 1ps
`default_nettype none

package tklr_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int LIFE_W       = 32;
    localparam int TAG_W        = 32;
    localparam int RANK_W       = 10;
    localparam int STORED_W     = 11;
    localparam int COUNT_W      = 32;
    localparam int SUM_W        = 48;
    // cells per first-level group of the read mux tree
    localparam int GROUP_SIZE   = 32;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_SELECT
    } t_state;

    typedef struct packed {
        logic [LIFE_W-1:0] life;
        logic [TAG_W-1:0]  tag;
    } t_entry;

endpackage

`default_nettype wire

FILE: rtl/tklr_cell.sv
// One cell of the sorted chain: holds one entry, takes the new pair or its left neighbor's.
`timescale 1ns / 1ps
`default_nettype none

module tklr_cell (
    input  wire logic            i_clk,
    input  wire logic            i_load,
    input  wire tklr_pkg::t_entry i_new,
    input  wire logic            i_occupied,
    input  wire logic            i_left_gt,
    input  wire tklr_pkg::t_entry i_left,
    output logic                 o_gt,
    output tklr_pkg::t_entry     o_entry
);

    tklr_pkg::t_entry r_entry;
    tklr_pkg::t_entry n_entry;

    // strict compare: a new pair goes behind stored pairs of equal lifetime
    assign o_gt = !i_occupied || (i_new.life > r_entry.life);

    always_comb begin
        n_entry = r_entry;
        if (i_load && o_gt) begin
            n_entry = i_left_gt ? i_left : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

FILE: rtl/tklr_read_tree.sv
// Two-level registered mux tree that picks the chain cell at a given rank.
`timescale 1ns / 1ps
`default_nettype none

module tklr_read_tree #(
    parameter int CAPACITY = tklr_pkg::CAPACITY_DEF
) (
    input  wire logic                        i_clk,
    input  wire tklr_pkg::t_entry            i_cells [CAPACITY],
    input  wire logic [tklr_pkg::RANK_W-1:0] i_rank,
    input  wire logic                        i_en_gather,
    input  wire logic                        i_en_select,
    output tklr_pkg::t_entry                 o_entry
);

    localparam int G    = tklr_pkg::GROUP_SIZE;
    localparam int LO_W = $clog2(G);
    localparam int NG   = (CAPACITY + G - 1) / G;
    localparam int HI_W = (NG > 1) ? $clog2(NG) : 1;
    localparam int NGP  = 1 << HI_W;

    tklr_pkg::t_entry w_pad [NGP*G];
    tklr_pkg::t_entry r_grp [NGP];
    tklr_pkg::t_entry r_entry;

    logic [LO_W-1:0] w_lo;
    logic [HI_W-1:0] w_hi;

    assign w_lo = i_rank[LO_W-1:0];
    assign w_hi = HI_W'(i_rank >> LO_W);

    for (genvar k = 0; k < NGP*G; k++) begin : g_pad
        if (k < CAPACITY) begin : g_cell
            assign w_pad[k] = i_cells[k];
        end else begin : g_zero
            assign w_pad[k] = '0;
        end
    end

    for (genvar g = 0; g < NGP; g++) begin : g_grp
        always_ff @(posedge i_clk) begin
            if (i_en_gather) begin
                r_grp[g] <= w_pad[g*G + int'(w_lo)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_select) begin
            r_entry <= r_grp[w_hi];
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

FILE: rtl/top_k_lifetime_retainer.sv
// Top level of the top-k lifetime retainer: sorted cell chain, counters and read path.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake               Payload
// command    in         start & !busy           i_operation, i_pair_lifetime, i_pair_tag, i_rank
// result     out        o_strobe (one cycle)    o_entry_*, o_stored_count, o_seen_count,
//                                               o_dropped_count, o_lifetime_sum
//
// Add: the new pair is broadcast to every cell of the chain and each cell decides locally,
//   so an add can follow in the next cycle; the result strobes in the cycle after the add.
// Read: busy in the gather and select states. The registered rank goes through a two-level
//   registered mux tree (group of 32 cells, then group select) before the result strobes.
// Reset clears the counters and the control state; cell contents are not cleared, the
//   stored count marks which cells hold data. No clearing pass is needed.
// The receiver cannot stall: each result transaction is shown for exactly one cycle.

module top_k_lifetime_retainer #(
    parameter int CAPACITY = tklr_pkg::CAPACITY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_operation,
    input  wire logic [tklr_pkg::LIFE_W-1:0]   i_pair_lifetime,
    input  wire logic [tklr_pkg::TAG_W-1:0]    i_pair_tag,
    input  wire logic [tklr_pkg::RANK_W-1:0]   i_rank,
    output logic                               o_strobe,
    output logic                               o_entry_valid,
    output logic [tklr_pkg::LIFE_W-1:0]        o_entry_lifetime,
    output logic [tklr_pkg::TAG_W-1:0]         o_entry_tag,
    output logic [tklr_pkg::STORED_W-1:0]      o_stored_count,
    output logic [tklr_pkg::COUNT_W-1:0]       o_seen_count,
    output logic [tklr_pkg::COUNT_W-1:0]       o_dropped_count,
    output logic [tklr_pkg::SUM_W-1:0]         o_lifetime_sum
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = tklr_pkg::SUM_W;
    localparam int CW    = tklr_pkg::COUNT_W;

    // ---------------- control ----------------
    tklr_pkg::t_state r_state, n_state;
    logic w_accept, w_add, w_read;
    logic w_en_gather, w_en_select;

    assign w_accept = start && !busy;
    assign w_add    = w_accept && (i_operation == tklr_pkg::OP_ADD);
    assign w_read   = w_accept && (i_operation == tklr_pkg::OP_READ);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tklr_pkg::ST_IDLE:   if (w_read) n_state = tklr_pkg::ST_GATHER;
            tklr_pkg::ST_GATHER: n_state = tklr_pkg::ST_SELECT;
            tklr_pkg::ST_SELECT: n_state = tklr_pkg::ST_IDLE;
            default:             n_state = tklr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        busy        = 1'b1;
        w_en_gather = 1'b0;
        w_en_select = 1'b0;
        unique case (r_state)
            tklr_pkg::ST_IDLE:   busy = 1'b0;
            tklr_pkg::ST_GATHER: w_en_gather = 1'b1;
            tklr_pkg::ST_SELECT: w_en_select = 1'b1;
            default:             busy = 1'b1;
        endcase
    end

    // ---------------- state registers ----------------
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CW-1:0]             r_seen, n_seen;
    logic [SUM_W-1:0]          r_sum, n_sum;
    logic [SUM_W:0]            w_sum_ext;
    logic [tklr_pkg::RANK_W-1:0] r_rank;
    logic                      r_rd_valid;
    logic                      r_rd_pending;
    logic                      r_strobe;
    logic                      r_is_read;

    assign w_sum_ext = {1'b0, r_sum} + (SUM_W+1)'(i_pair_lifetime);

    always_comb begin
        n_count = r_count;
        n_seen  = r_seen;
        n_sum   = r_sum;
        if (w_add) begin
            // full store keeps its count: one evicted, one inserted, or dropped
            if (r_count < CNT_W'(CAPACITY)) begin
                n_count = r_count + 1'b1;
            end
            if (r_seen != '1) begin
                n_seen = r_seen + 1'b1;
            end
            n_sum = w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tklr_pkg::ST_IDLE;
            r_count      <= '0;
            r_seen       <= '0;
            r_sum        <= '0;
            r_strobe     <= 1'b0;
            r_is_read    <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_rd_pending <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_seen   <= n_seen;
            r_sum    <= n_sum;
            r_strobe <= w_add || w_en_select;
            if (w_add) begin
                r_is_read <= 1'b0;
            end else if (w_en_select) begin
                r_is_read <= r_rd_pending;
            end
            if (w_read) begin
                r_rd_pending <= 1'b1;
                r_rd_valid   <= (32'(i_rank) < 32'(r_count))
                             && (32'(i_rank) < 32'(CAPACITY));
            end else if (w_en_select) begin
                r_rd_pending <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_read) begin
            r_rank <= i_rank;
        end
    end

    // ---------------- sorted cell chain ----------------
    tklr_pkg::t_entry w_new;
    tklr_pkg::t_entry w_cell [CAPACITY];
    logic             w_gt   [CAPACITY];

    assign w_new = '{life: i_pair_lifetime, tag: i_pair_tag};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic             w_occ;
        logic             w_left_gt;
        tklr_pkg::t_entry w_left;

        assign w_occ = r_count > CNT_W'(i);

        if (i == 0) begin : g_head
            assign w_left_gt = 1'b0;
            assign w_left    = '0;
        end else begin : g_body
            assign w_left_gt = w_gt[i-1];
            assign w_left    = w_cell[i-1];
        end

        tklr_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (w_add),
            .i_new      (w_new),
            .i_occupied (w_occ),
            .i_left_gt  (w_left_gt),
            .i_left     (w_left),
            .o_gt       (w_gt[i]),
            .o_entry    (w_cell[i])
        );
    end

    // ---------------- read path ----------------
    tklr_pkg::t_entry w_read_entry;

    tklr_read_tree #(
        .CAPACITY (CAPACITY)
    ) u_read_tree (
        .i_clk       (i_clk),
        .i_cells     (w_cell),
        .i_rank      (r_rank),
        .i_en_gather (w_en_gather),
        .i_en_select (w_en_select),
        .o_entry     (w_read_entry)
    );

    // ---------------- result ----------------
    logic w_show;

    // entry data only on the strobed cycle of a read result
    assign w_show           = r_strobe && r_is_read && r_rd_valid;
    assign o_strobe         = r_strobe;
    assign o_entry_valid    = w_show;
    assign o_entry_lifetime = w_show ? w_read_entry.life : '0;
    assign o_entry_tag      = w_show ? w_read_entry.tag  : '0;
    assign o_stored_count   = tklr_pkg::STORED_W'(r_count);
    assign o_seen_count     = r_seen;
    assign o_dropped_count  = (r_seen > CW'(CAPACITY)) ? (r_seen - CW'(CAPACITY)) : '0;
    assign o_lifetime_sum   = r_sum;

`ifndef SYNTHESIS
    // a read keeps the block busy through the gather and select states, then strobes with busy low
    a_read_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_read |=> busy ##1 busy ##1 (o_strobe && !busy))
        else $error("read result timing broken");

    // an add strobes next cycle with no entry data
    a_add_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_add |=> (o_strobe && !o_entry_valid))
        else $error("add result missing or carries entry");

    // stored count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("stored count above capacity");

    // entry data only appears on a strobed transaction
    a_valid_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_valid |-> o_strobe)
        else $error("entry valid without strobe");
`endif

endmodule

`default_nettype wire
